// File: src/asf_data_packet_parser_defines.svh
// Assertion macros for the checker of the ASF packet parser.
// Depends on nothing.
`ifndef ASF_DATA_PACKET_PARSER_DEFINES_SVH
`define ASF_DATA_PACKET_PARSER_DEFINES_SVH
// Checks that a condition implies a consequence in the same cycle.
`define ASF_ASSERT_IMPL(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define ASF_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// File: src/asfp_pkg.sv
// ASF parser package: phases, error codes, config indexes, result type and field length helper.
// Used by the parser core, the top level and the checker.
`timescale 1ns / 1ps
package asfp_pkg;
    localparam int MaxSegmentsDefault = 63;

    typedef enum logic [4:0] {
        PH_LEAD, PH_ZERO, PH_FLAGS, PH_SEGTYPE, PH_PSIZE, PH_PAD, PH_SEND, PH_DUR,
        PH_COUNT, PH_SSTREAM, PH_SSEQ, PH_SOFF, PH_SFLAGS, PH_GUNK, PH_GLEN,
        PH_GPLEN, PH_GDATA, PH_OLEN, PH_OTIME, PH_ODLEN, PH_OSKIP, PH_ODATA,
        PH_PADSKIP, PH_ERR
    } t_phase;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_LEAD     = 4'd1;
    localparam logic [3:0] ERR_RESERVED = 4'd2;
    localparam logic [3:0] ERR_SEGTYPE  = 4'd3;
    localparam logic [3:0] ERR_SEGFLAGS = 4'd4;
    localparam logic [3:0] ERR_LENGTH   = 4'd5;
    localparam logic [3:0] ERR_COUNT    = 4'd6;
    localparam logic [3:0] ERR_SEGMENTS = 4'd7;
    localparam logic [3:0] ERR_STREAM   = 4'd8;
    localparam logic [3:0] ERR_SEQUENCE = 4'd9;
    localparam logic [3:0] ERR_GROUPING = 4'd10;

    localparam logic [1:0] CFG_PACKET_SIZE  = 2'd0;
    localparam logic [1:0] CFG_PACKET_COUNT = 2'd1;
    localparam logic [1:0] CFG_EXP_STREAM   = 2'd2;
    localparam logic [1:0] CFG_AUDIO_CHECKS = 2'd3;

    typedef struct packed {
        logic        is_error;
        logic [3:0]  code;
        logic [7:0]  data;
        logic [21:0] segment;
        logic        first;
        logic        last;
        logic [31:0] send_time;
        logic [15:0] duration;
    } t_result;

    // Number of bytes in the field read in a phase.
    function automatic logic [2:0] field_len(t_phase ph, logic [7:0] lflags,
                                             logic [7:0] stype, logic [7:0] cbyte);
        logic [2:0] n;
        n = 3'd1;
        case (ph)
            PH_ZERO, PH_PSIZE, PH_DUR, PH_GLEN: n = 3'd2;
            PH_SEND, PH_OLEN, PH_OTIME:         n = 3'd4;
            PH_PAD:   n = lflags[4] ? 3'd2 : 3'd1;
            PH_SOFF:  n = (stype == 8'h55) ? 3'd1 : ((stype == 8'h59) ? 3'd2 : 3'd4);
            PH_ODLEN: n = cbyte[6] ? 3'd1 : 3'd2;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction
endpackage

// File: src/asfp_core.sv
// Byte-serial parse engine of the ASF packet parser: one byte in, at most one result out.
// Depends on asfp_pkg.
`timescale 1ns / 1ps
module asfp_core #(
    parameter int MAX_SEGMENTS = asfp_pkg::MaxSegmentsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_packet_size,
    input  logic [31:0]        i_packet_count,
    input  logic [6:0]         i_expected_stream,
    input  logic               i_audio_checks,
    output logic               o_res_valid,
    output asfp_pkg::t_result  o_res
);
    localparam logic [5:0] MaxSeg = 6'(MAX_SEGMENTS);

    asfp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_poff, n_poff;
    logic [31:0] r_shift, n_shift;
    logic [2:0]  r_left, n_left;
    logic [7:0]  r_lflags, n_lflags, r_stype, n_stype, r_cbyte, n_cbyte;
    logic [5:0]  r_segs, n_segs;
    logic [15:0] r_pad, n_pad;
    logic [31:0] r_foff, n_foff, r_pleft, n_pleft;
    logic [7:0]  r_piece, n_piece;
    logic [15:0] r_ptotal, n_ptotal;
    logic [31:0] r_pdone, n_pdone;
    logic [7:0]  r_seq, n_seq;
    logic        r_err, n_err;
    logic [31:0] r_send, n_send;
    logic [15:0] r_dur, n_dur;
    logic [21:0] r_cur, n_cur;
    logic        r_fresh, n_fresh;

    logic        emit, fail, fire;
    logic [3:0]  code;
    logic [7:0]  ebyte;
    logic        efirst, elast;
    logic [31:0] fs, v;
    logic [2:0]  fl;
    logic [17:0] slen_a;
    logic [33:0] slen_b;
    logic [7:0]  pl_dec;
    logic [31:0] pay_dec;

    // The chain of follow-on actions is flattened into these flags.
    logic do_end_seg, do_start_seg, do_start_pad, do_end_pkt;

    always_comb begin
        n_phase = r_phase; n_poff = r_poff; n_shift = r_shift; n_left = r_left;
        n_lflags = r_lflags; n_stype = r_stype; n_cbyte = r_cbyte; n_segs = r_segs;
        n_pad = r_pad; n_foff = r_foff; n_pleft = r_pleft; n_piece = r_piece;
        n_ptotal = r_ptotal; n_pdone = r_pdone; n_seq = r_seq; n_err = r_err;
        n_send = r_send; n_dur = r_dur; n_cur = r_cur; n_fresh = r_fresh;
        emit = 1'b0; fail = 1'b0; code = asfp_pkg::ERR_NONE;
        ebyte = i_byte; efirst = 1'b0; elast = 1'b0;
        do_end_seg = 1'b0; do_start_seg = 1'b0; do_start_pad = 1'b0; do_end_pkt = 1'b0;
        fs = {i_byte, r_shift[31:8]};
        fl = asfp_pkg::field_len(r_phase, r_lflags, r_stype, r_cbyte);
        v = fs >> (6'd32 - {fl, 3'b000});
        slen_a = 18'd0; slen_b = 34'd0;
        pl_dec = r_piece - 8'd1;
        pay_dec = r_pleft - 32'd1;
        fire = 1'b0;
        if (i_step && !r_err) begin
            if (r_phase == asfp_pkg::PH_LEAD && r_poff == 16'd0 && r_pdone == i_packet_count)
                begin
                fail = 1'b1; code = asfp_pkg::ERR_COUNT;
            end else if (r_poff >= i_packet_size) begin
                fail = 1'b1; code = asfp_pkg::ERR_LENGTH;
            end else begin
                n_poff = r_poff + 16'd1;
                case (r_phase)
                    asfp_pkg::PH_GDATA: begin
                        emit = 1'b1; efirst = r_fresh; n_fresh = 1'b0;
                        n_piece = pl_dec;
                        if (r_pleft != 32'd0) n_pleft = pay_dec;
                        elast = (pl_dec == 8'd0);
                        if (pl_dec == 8'd0) begin
                            if (n_pleft == 32'd0) do_end_seg = 1'b1;
                            else begin
                                n_phase = asfp_pkg::PH_GPLEN; n_left = 3'd1; n_shift = '0;
                            end
                        end
                    end
                    asfp_pkg::PH_OSKIP: begin
                        n_foff = r_foff - 32'd1;
                        if (n_foff == 32'd0) begin
                            if (r_pleft == 32'd0) do_end_seg = 1'b1;
                            else n_phase = asfp_pkg::PH_ODATA;
                        end
                    end
                    asfp_pkg::PH_ODATA: begin
                        emit = 1'b1; efirst = r_fresh; n_fresh = 1'b0;
                        n_pleft = pay_dec; elast = (pay_dec == 32'd0);
                        if (pay_dec == 32'd0) do_end_seg = 1'b1;
                    end
                    asfp_pkg::PH_PADSKIP: begin
                        n_pad = r_pad - 16'd1;
                        if (n_pad == 16'd0) do_end_pkt = 1'b1;
                    end
                    default: begin
                        n_shift = fs;
                        if (r_left > 3'd1) n_left = r_left - 3'd1;
                        else begin
                            n_left = 3'd0;
                            fire = 1'b1;
                        end
                    end
                endcase
                if (fire) begin
                    case (r_phase)
                        asfp_pkg::PH_LEAD:
                            if (v[7:0] != 8'h82) begin
                                fail = 1'b1; code = asfp_pkg::ERR_LEAD;
                            end else n_phase = asfp_pkg::PH_ZERO;
                        asfp_pkg::PH_ZERO:
                            if (v[15:0] != 16'd0) begin
                                fail = 1'b1; code = asfp_pkg::ERR_RESERVED;
                            end else n_phase = asfp_pkg::PH_FLAGS;
                        asfp_pkg::PH_FLAGS: begin
                            n_lflags = v[7:0]; n_phase = asfp_pkg::PH_SEGTYPE;
                        end
                        asfp_pkg::PH_SEGTYPE, asfp_pkg::PH_PSIZE: begin
                            if (r_phase == asfp_pkg::PH_SEGTYPE) n_stype = v[7:0];
                            if (r_phase == asfp_pkg::PH_SEGTYPE && r_lflags[6])
                                n_phase = asfp_pkg::PH_PSIZE;
                            else begin
                                n_pad = 16'd0;
                                n_phase = (r_lflags[4] || r_lflags[3]) ?
                                          asfp_pkg::PH_PAD : asfp_pkg::PH_SEND;
                            end
                        end
                        asfp_pkg::PH_PAD: begin
                            n_pad = v[15:0]; n_phase = asfp_pkg::PH_SEND;
                        end
                        asfp_pkg::PH_SEND: begin
                            n_send = v; n_phase = asfp_pkg::PH_DUR;
                        end
                        asfp_pkg::PH_DUR, asfp_pkg::PH_COUNT: begin
                            if (r_phase == asfp_pkg::PH_DUR) n_dur = v[15:0];
                            if (r_phase == asfp_pkg::PH_DUR && r_lflags[0])
                                n_phase = asfp_pkg::PH_COUNT;
                            else begin
                                n_cbyte = (r_phase == asfp_pkg::PH_DUR) ? 8'd1 : v[7:0];
                                n_segs = n_cbyte[5:0];
                                n_cur[5:0] = 6'd0;
                                if (n_segs > MaxSeg ||
                                    (i_audio_checks && n_segs != 6'd1)) begin
                                    fail = 1'b1; code = asfp_pkg::ERR_SEGMENTS;
                                end else do_start_seg = 1'b1;
                            end
                        end
                        asfp_pkg::PH_SSTREAM: begin
                            n_cur[12:6] = v[6:0]; n_cur[13] = v[7];
                            if (i_audio_checks && v[6:0] != i_expected_stream) begin
                                fail = 1'b1; code = asfp_pkg::ERR_STREAM;
                            end else n_phase = asfp_pkg::PH_SSEQ;
                        end
                        asfp_pkg::PH_SSEQ: begin
                            n_cur[21:14] = v[7:0];
                            if (r_stype != 8'h55 && r_stype != 8'h59 && r_stype != 8'h5D) begin
                                fail = 1'b1; code = asfp_pkg::ERR_SEGTYPE;
                            end else if (i_audio_checks && v[7:0] != r_seq) begin
                                fail = 1'b1; code = asfp_pkg::ERR_SEQUENCE;
                            end else begin
                                if (i_audio_checks) n_seq = r_seq + 8'd1;
                                n_phase = asfp_pkg::PH_SOFF;
                            end
                        end
                        asfp_pkg::PH_SOFF: begin
                            n_foff = v; n_phase = asfp_pkg::PH_SFLAGS;
                        end
                        asfp_pkg::PH_SFLAGS:
                            if (v[7:0] == 8'h01) n_phase = asfp_pkg::PH_GUNK;
                            else if (v[7:0] == 8'h08) n_phase = asfp_pkg::PH_OLEN;
                            else begin
                                fail = 1'b1; code = asfp_pkg::ERR_SEGFLAGS;
                            end
                        asfp_pkg::PH_GUNK, asfp_pkg::PH_GLEN: begin
                            if (r_phase == asfp_pkg::PH_GUNK && r_cbyte[5:0] != 6'd1)
                                n_phase = asfp_pkg::PH_GLEN;
                            else begin
                                if (r_phase == asfp_pkg::PH_GUNK) begin
                                    slen_a = {2'b00, i_packet_size} - {2'b00, n_poff}
                                             - {2'b00, r_pad};
                                    n_pleft = {{14{slen_a[17]}}, slen_a};
                                end else n_pleft = {16'd0, v[15:0]};
                                if (r_phase == asfp_pkg::PH_GUNK && slen_a[17]) begin
                                    fail = 1'b1; code = asfp_pkg::ERR_LENGTH;
                                end else if (n_pleft == 32'd0) do_end_seg = 1'b1;
                                else n_phase = asfp_pkg::PH_GPLEN;
                            end
                        end
                        asfp_pkg::PH_GPLEN: begin
                            n_pleft = pay_dec;
                            if (i_audio_checks && r_ptotal != 16'd0) begin
                                fail = 1'b1; code = asfp_pkg::ERR_GROUPING;
                            end else begin
                                if (r_ptotal != 16'hFFFF) n_ptotal = r_ptotal + 16'd1;
                                n_piece = v[7:0]; n_fresh = 1'b1;
                                if (v[7:0] != 8'd0) n_phase = asfp_pkg::PH_GDATA;
                                else if (pay_dec == 32'd0) do_end_seg = 1'b1;
                                else n_phase = asfp_pkg::PH_GPLEN;
                            end
                        end
                        asfp_pkg::PH_OLEN: n_phase = asfp_pkg::PH_OTIME;
                        asfp_pkg::PH_OTIME, asfp_pkg::PH_ODLEN: begin
                            if (r_phase == asfp_pkg::PH_OTIME && r_cbyte[5:0] != 6'd1)
                                n_phase = asfp_pkg::PH_ODLEN;
                            else begin
                                if (r_phase == asfp_pkg::PH_OTIME) begin
                                    slen_b = {18'd0, i_packet_size} - {18'd0, n_poff}
                                             - {18'd0, r_pad} - {2'b00, r_foff};
                                    n_pleft = slen_b[31:0];
                                end else n_pleft = {16'd0, v[15:0]};
                                if (r_phase == asfp_pkg::PH_OTIME && slen_b[33]) begin
                                    fail = 1'b1; code = asfp_pkg::ERR_LENGTH;
                                end else begin
                                    n_ptotal = 16'd1; n_fresh = 1'b1;
                                    if (r_foff != 32'd0) n_phase = asfp_pkg::PH_OSKIP;
                                    else if (n_pleft == 32'd0) do_end_seg = 1'b1;
                                    else n_phase = asfp_pkg::PH_ODATA;
                                end
                            end
                        end
                        default: begin
                            fail = 1'b1; code = asfp_pkg::ERR_LENGTH;
                        end
                    endcase
                    if (!fail && n_phase != r_phase) begin
                        n_left = asfp_pkg::field_len(n_phase, n_lflags, n_stype, n_cbyte);
                        n_shift = '0;
                    end
                end
            end
            if (do_end_seg) begin
                if (i_audio_checks && n_ptotal != 16'd1) begin
                    fail = 1'b1; code = asfp_pkg::ERR_GROUPING;
                end else begin
                    n_segs = r_segs - 6'd1;
                    n_cur[5:0] = r_cur[5:0] + 6'd1;
                    do_start_seg = 1'b1;
                end
            end
            if (do_start_seg && !fail) begin
                n_ptotal = 16'd0;
                if (n_segs == 6'd0) do_start_pad = 1'b1;
                else begin
                    n_phase = asfp_pkg::PH_SSTREAM; n_left = 3'd1; n_shift = '0;
                end
            end
            if (do_start_pad) begin
                if (n_pad == 16'd0) do_end_pkt = 1'b1;
                else n_phase = asfp_pkg::PH_PADSKIP;
            end
            if (do_end_pkt) begin
                n_pdone = r_pdone + 32'd1;
                if (n_poff != i_packet_size) begin
                    fail = 1'b1; code = asfp_pkg::ERR_LENGTH;
                end else begin
                    n_poff = 16'd0;
                    n_phase = asfp_pkg::PH_LEAD; n_left = 3'd1; n_shift = '0;
                end
            end
            if (fail) begin
                n_err = 1'b1; n_phase = asfp_pkg::PH_ERR; emit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= asfp_pkg::PH_LEAD; r_poff <= '0; r_shift <= '0; r_left <= 3'd1;
            r_lflags <= '0; r_stype <= '0; r_cbyte <= '0; r_segs <= '0; r_pad <= '0;
            r_foff <= '0; r_pleft <= '0; r_piece <= '0; r_ptotal <= '0; r_pdone <= '0;
            r_seq <= 8'd1; r_err <= 1'b0; r_send <= '0; r_dur <= '0; r_cur <= '0;
            r_fresh <= 1'b0; o_res_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_poff <= n_poff; r_shift <= n_shift; r_left <= n_left;
            r_lflags <= n_lflags; r_stype <= n_stype; r_cbyte <= n_cbyte; r_segs <= n_segs;
            r_pad <= n_pad; r_foff <= n_foff; r_pleft <= n_pleft; r_piece <= n_piece;
            r_ptotal <= n_ptotal; r_pdone <= n_pdone; r_seq <= n_seq; r_err <= n_err;
            r_send <= n_send; r_dur <= n_dur; r_cur <= n_cur; r_fresh <= n_fresh;
            o_res_valid <= fail || emit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.is_error  <= fail;
        o_res.code      <= fail ? code : asfp_pkg::ERR_NONE;
        o_res.data      <= fail ? 8'd0 : ebyte;
        o_res.segment   <= n_cur;
        o_res.first     <= fail ? 1'b0 : efirst;
        o_res.last      <= fail ? 1'b0 : elast;
        o_res.send_time <= n_send;
        o_res.duration  <= n_dur;
    end
endmodule

// File: src/asf_data_packet_parser.sv
// Top level of the ASF data-packet parser: stream ports, configuration registers, output skid.
// Depends on asfp_pkg and asfp_core.
`timescale 1ns / 1ps
// Usage: bytes of fixed-size ASF data packets enter on the s_axis channel, one per request,
// in tdata. Results leave on m_axis: payload bytes (tuser = 0) or one error report
// (tuser = 1), with the segment, piece and packet timing fields alongside in tdata.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// The core registers the result of an accepted request, and the output register then
// presents it on m_axis.
// Throughput is one byte per cycle while s_axis_tready is high; the parse engine handles
// each byte in a single registered step, so many bytes produce no result (headers, padding).
// After reset the parser expects a lead byte, the sequence counter is one and the
// configuration registers hold their reset values.
// When the receiver stalls, one result is held in the output register and another in
// the skid register; s_axis_tready falls while the skid register is occupied, or while a
// stalled output register would leave no room for the result still in the core.
// After the first error is reported every further byte is accepted and dropped.
module asf_data_packet_parser #(
    parameter int MAX_SEGMENTS = asfp_pkg::MaxSegmentsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // stream_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // error_code, payload_byte, segment_index, segment_stream, keyframe,
    // segment_sequence, piece_first, piece_last, send_time, packet_duration; 4 zero bits
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tuser,   // kind
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    logic [15:0] r_psize;
    logic [31:0] r_pcount;
    logic [6:0]  r_estream;
    logic        r_audio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psize <= '0; r_pcount <= '0; r_estream <= 7'd1; r_audio <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                asfp_pkg::CFG_PACKET_SIZE:  r_psize   <= i_cfg_data[15:0];
                asfp_pkg::CFG_PACKET_COUNT: r_pcount  <= i_cfg_data;
                asfp_pkg::CFG_EXP_STREAM:   r_estream <= i_cfg_data[6:0];
                asfp_pkg::CFG_AUDIO_CHECKS: r_audio   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic              step, core_valid;
    asfp_pkg::t_result core_res;
    asfp_pkg::t_result r_out, r_skid;
    logic              r_out_v, r_skid_v;

    // Buffered results plus the one in the core must leave a free slot for a new request.
    assign s_axis_tready = !r_skid_v && !(r_out_v && core_valid && !m_axis_tready);
    assign step = s_axis_tvalid && s_axis_tready;

    asfp_core #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(s_axis_tdata),
        .i_packet_size(r_psize), .i_packet_count(r_pcount),
        .i_expected_stream(r_estream), .i_audio_checks(r_audio),
        .o_res_valid(core_valid), .o_res(core_res)
    );

    logic take;
    assign take = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_v) begin
                    r_out <= r_skid; r_out_v <= 1'b1;
                    r_skid_v <= core_valid; r_skid <= core_res;
                end else begin
                    r_out <= core_res; r_out_v <= core_valid;
                end
            end else if (core_valid) begin
                r_skid <= core_res; r_skid_v <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.is_error;
    assign m_axis_tdata  = {4'd0, r_out.duration, r_out.send_time, r_out.last, r_out.first,
                            r_out.segment[21:14], r_out.segment[13], r_out.segment[12:6],
                            r_out.segment[5:0], r_out.data, r_out.code};
endmodule

// File: src/asfp_checker.sv
// Port-level checker for the ASF packet parser, bound to the top level.
// Depends on asf_data_packet_parser_defines.svh and asfp_pkg.
`timescale 1ns / 1ps
`include "asf_data_packet_parser_defines.svh"
module asfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    logic [88:0] m_word;
    logic        stall, err_out, pay_out, err_taken, err_ok, pay_ok;

    assign m_word    = {m_axis_tuser, m_axis_tdata};
    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign err_out   = m_axis_tvalid && m_axis_tuser;
    assign pay_out   = m_axis_tvalid && !m_axis_tuser;
    assign err_taken = err_out && m_axis_tready;
    assign err_ok    = m_axis_tdata[3:0] != asfp_pkg::ERR_NONE && m_axis_tdata[11:4] == 8'd0;
    assign pay_ok    = m_axis_tdata[3:0] == asfp_pkg::ERR_NONE;

    // A stalled result holds its value.
    `ASF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, m_axis_tvalid && $stable(m_word), "stall broke")
    // Error reports carry a non-zero code and no payload byte.
    `ASF_ASSERT_IMPL(a_err_code, i_clk, i_rst_n, err_out, err_ok, "bad error report")
    // Payload results carry no code.
    `ASF_ASSERT_IMPL(a_pay_code, i_clk, i_rst_n, pay_out, pay_ok, "payload with code")
    // The error report is the last result until reset.
    `ASF_ASSERT_NEXT(a_err_last, i_clk, i_rst_n, err_taken, !m_axis_tvalid, "result after error")
endmodule

bind asf_data_packet_parser asfp_checker u_asfp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
